### rtl/arpc_pkg.sv
// Package with the shared types, codes and helper functions of the ARP cache lookup block.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;

   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int PREFIX_W = 6;
   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 3;

   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LEARN  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_HIT      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;

   localparam logic [PREFIX_W-1:0] EXACT_PREFIX = 6'd1;
   localparam logic [PREFIX_W-1:0] FULL_PREFIX  = 6'd32;

   typedef struct packed {
      logic [IP_W-1:0]     ip;
      logic [PREFIX_W-1:0] prefix;
      logic [MAC_W-1:0]    mac;
   } entry_type;

   function automatic logic [IP_W-1:0] prefix_to_mask(input logic [PREFIX_W-1:0] p);
      logic [IP_W-1:0] m;
      if (p == '0) begin
         m = '0;
      end else if (p >= FULL_PREFIX) begin
         m = '1;
      end else begin
         m = ~({IP_W{1'b1}} >> p);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

### rtl/arpc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/arp_cache_prefix_lookup_top.sv
// Top level of the ARP cache with longest-prefix lookup, learn and add operations.
`timescale 1ns / 1ps
`default_nettype none
// The block holds up to TABLE_DEPTH entries in one RAM in insertion order and works on one
// operation at a time. A lookup or learn reads the stored entries one per cycle from oldest to
// newest through the single read port of the entry RAM; an entry of prefix 1 that matches
// exactly ends the scan early. An add skips the scan and goes straight to the result state.
// A learn that misses or an add with room writes the new entry in the cycle the result is
// registered. The result register lets the next request be accepted while the previous result
// is still stalled.
module arp_cache_prefix_lookup_top #(
   parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [arpc_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [arpc_pkg::IP_W-1:0]      req_ip_addr,
   input  wire logic [arpc_pkg::MAC_W-1:0]     req_mac_addr,
   input  wire logic [arpc_pkg::PREFIX_W-1:0]  req_prefix_len,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [arpc_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [arpc_pkg::MAC_W-1:0]     rsp_found_mac,
   output logic      [arpc_pkg::PREFIX_W-1:0]  rsp_matched_prefix
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic          hit_ff, hit_in;
   logic [arpc_pkg::PREFIX_W-1:0] best_ff, best_in;
   logic [arpc_pkg::MAC_W-1:0]    best_mac_ff, best_mac_in;

   logic [arpc_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic [arpc_pkg::IP_W-1:0]     ip_ff, ip_in;
   logic [arpc_pkg::MAC_W-1:0]    mac_ff, mac_in;
   logic [arpc_pkg::PREFIX_W-1:0] plen_ff, plen_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [arpc_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [arpc_pkg::MAC_W-1:0]    rsp_mac_ff, rsp_mac_in;
   logic [arpc_pkg::PREFIX_W-1:0] rsp_prefix_ff, rsp_prefix_in;

   logic                  accept;
   logic                  issue;
   logic                  exact_win;
   logic                  lpm_win;
   logic                  out_free;
   logic                  full;
   logic                  wr_en;
   logic [arpc_pkg::IP_W-1:0] ent_mask;
   logic [$bits(arpc_pkg::entry_type)-1:0] rd_bits;
   arpc_pkg::entry_type   ent;
   arpc_pkg::entry_type   wr_ent;

   arpc_ram #(
      .WIDTH ($bits(arpc_pkg::entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_ent),
      .rd_en   (issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_bits)
   );

   assign ent       = arpc_pkg::entry_type'(rd_bits);
   assign ent_mask  = arpc_pkg::prefix_to_mask(ent.prefix);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign issue     = (state_ff == S_SCAN) && (idx_ff < count_ff);
   assign exact_win = pend_ff && (ent.prefix == arpc_pkg::EXACT_PREFIX) && (ent.ip == ip_ff);
   assign lpm_win   = pend_ff && (ent.prefix != arpc_pkg::EXACT_PREFIX)
                      && ((ip_ff & ent_mask) == (ent.ip & ent_mask)) && (ent.prefix > best_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (count_ff == DEPTH_C);

   always_comb begin
      wr_ent.ip     = ip_ff;
      wr_ent.mac    = mac_ff;
      if (op_ff == arpc_pkg::OP_ADD) begin
         wr_ent.prefix = (plen_ff > arpc_pkg::FULL_PREFIX) ? arpc_pkg::FULL_PREFIX : plen_ff;
      end else begin
         wr_ent.prefix = arpc_pkg::FULL_PREFIX;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      hit_in        = hit_ff;
      best_in       = best_ff;
      best_mac_in   = best_mac_ff;
      op_in         = op_ff;
      ip_in         = ip_ff;
      mac_in        = mac_ff;
      plen_in       = plen_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_mac_in    = rsp_mac_ff;
      rsp_prefix_in = rsp_prefix_ff;
      wr_en         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_opcode;
               ip_in       = req_ip_addr;
               mac_in      = req_mac_addr;
               plen_in     = req_prefix_len;
               idx_in      = '0;
               hit_in      = 1'b0;
               best_in     = '0;
               best_mac_in = '0;
               state_in    = (req_opcode == arpc_pkg::OP_ADD) ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (exact_win) begin
               hit_in      = 1'b1;
               best_in     = ent.prefix;
               best_mac_in = ent.mac;
               state_in    = S_FINISH;
            end else begin
               pend_in = issue;
               if (lpm_win) begin
                  hit_in      = 1'b1;
                  best_in     = ent.prefix;
                  best_mac_in = ent.mac;
               end
               if (!issue) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_mac_in    = '0;
               rsp_prefix_in = '0;
               state_in      = S_IDLE;
               if (op_ff == arpc_pkg::OP_LEARN && hit_ff) begin
                  rsp_status_in = arpc_pkg::STATUS_PRESENT;
               end else if (op_ff == arpc_pkg::OP_LEARN || op_ff == arpc_pkg::OP_ADD) begin
                  if (full) begin
                     rsp_status_in = arpc_pkg::STATUS_FULL;
                  end else begin
                     rsp_status_in = arpc_pkg::STATUS_INSERTED;
                     wr_en         = 1'b1;
                     count_in      = count_ff + CW'(1);
                  end
               end else if (hit_ff) begin
                  rsp_status_in = arpc_pkg::STATUS_HIT;
                  rsp_mac_in    = best_mac_ff;
                  rsp_prefix_in = best_ff;
               end else begin
                  rsp_status_in = arpc_pkg::STATUS_MISS;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      best_ff       <= best_in;
      best_mac_ff   <= best_mac_in;
      op_ff         <= op_in;
      ip_ff         <= ip_in;
      mac_ff        <= mac_in;
      plen_ff       <= plen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mac_ff    <= rsp_mac_in;
      rsp_prefix_ff <= rsp_prefix_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_mac      = rsp_mac_ff;
   assign rsp_matched_prefix = rsp_prefix_ff;

endmodule
`default_nettype wire
